[design/mpmc_pkg.sv]
// Package for the multi-pattern match counter.
// Holds item types, memory request types, codes and address helpers.
// No dependencies.
`default_nettype none
package mpmc_pkg;
    localparam int NODE_LIMIT  = 1024;
    localparam int NODE_W      = $clog2(NODE_LIMIT);
    localparam int TOTAL_W     = NODE_W + 1;
    localparam int PAT_LIMIT   = 1024;
    localparam int PAT_W       = 10;
    localparam int PAT_AW      = $clog2(PAT_LIMIT);
    localparam int TAG_W       = PAT_W + 1;
    localparam int ALPHA       = 26;
    localparam int LETTER_W    = $clog2(ALPHA);
    localparam int COUNT_W     = 24;
    localparam int CHILD_DEPTH = NODE_LIMIT * ALPHA;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int QUEUE_W     = $clog2(NODE_LIMIT) + 1;
    localparam int SWEEP_W     = (PAT_AW > LETTER_W) ? PAT_AW : LETTER_W;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_PCHAR = 3'd1,
        ACT_PEND  = 3'd2,
        ACT_BUILD = 3'd3,
        ACT_TEXT  = 3'd4,
        ACT_READ  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]       action;
        logic [7:0]       symbol;
        logic [PAT_W-1:0] pattern_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] match_count;
        logic [NODE_W-1:0]  current_node;
    } t_out_item;

    typedef struct packed {
        logic                child_we;
        logic [CHILD_AW-1:0] child_waddr;
        logic [NODE_W-1:0]   child_wdata;
        logic [CHILD_AW-1:0] child_raddr;
        logic                fail_we;
        logic [NODE_W-1:0]   fail_waddr;
        logic [NODE_W-1:0]   fail_wdata;
        logic [NODE_W-1:0]   fail_raddr;
        logic                tag_we;
        logic [NODE_W-1:0]   tag_waddr;
        logic [TAG_W-1:0]    tag_wdata;
        logic [NODE_W-1:0]   tag_raddr;
        logic                queue_we;
        logic [NODE_W-1:0]   queue_waddr;
        logic [NODE_W-1:0]   queue_wdata;
        logic [NODE_W-1:0]   queue_raddr;
        logic                hit_we;
        logic [PAT_AW-1:0]   hit_waddr;
        logic [COUNT_W-1:0]  hit_wdata;
        logic [PAT_AW-1:0]   hit_raddr;
    } t_mem_req;

    typedef struct packed {
        logic [NODE_W-1:0]  child;
        logic [NODE_W-1:0]  fail;
        logic [TAG_W-1:0]   tag;
        logic [NODE_W-1:0]  queue;
        logic [COUNT_W-1:0] hit;
    } t_mem_rd;

    function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                       input logic [LETTER_W-1:0] letter);
        child_addr = CHILD_AW'(node) * CHILD_AW'(ALPHA) + CHILD_AW'(letter);
    endfunction

    function automatic logic is_letter(input logic [7:0] sym);
        is_letter = (sym >= CHAR_A) && (sym <= CHAR_Z);
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(input logic [7:0] sym);
        logic [7:0] d;
        d = sym - CHAR_A;
        letter_of = d[LETTER_W-1:0];
    endfunction
endpackage
`default_nettype wire

[design/mpmc_store.sv]
// Node, link, tag, queue and count memories of the match counter.
// One write and one registered read per memory each cycle; uses mpmc_pkg.
`default_nettype none
module mpmc_store (
    input  wire logic              i_clk,
    input  wire mpmc_pkg::t_mem_req i_req,
    output mpmc_pkg::t_mem_rd      o_rd
);
    import mpmc_pkg::*;

    logic [NODE_W-1:0]  r_child [CHILD_DEPTH];
    logic [NODE_W-1:0]  r_fail  [NODE_LIMIT];
    logic [TAG_W-1:0]   r_tag   [NODE_LIMIT];
    logic [NODE_W-1:0]  r_queue [NODE_LIMIT];
    logic [COUNT_W-1:0] r_hit   [PAT_LIMIT];

    logic [NODE_W-1:0]  r_rd_child;
    logic [NODE_W-1:0]  r_rd_fail;
    logic [TAG_W-1:0]   r_rd_tag;
    logic [NODE_W-1:0]  r_rd_queue;
    logic [COUNT_W-1:0] r_rd_hit;

    assign o_rd = '{child: r_rd_child, fail: r_rd_fail, tag: r_rd_tag,
                    queue: r_rd_queue, hit: r_rd_hit};

    always_ff @(posedge i_clk) begin
        if (i_req.child_we) begin
            r_child[i_req.child_waddr] <= i_req.child_wdata;
        end
        r_rd_child <= r_child[i_req.child_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.fail_we) begin
            r_fail[i_req.fail_waddr] <= i_req.fail_wdata;
        end
        r_rd_fail <= r_fail[i_req.fail_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.tag_we) begin
            r_tag[i_req.tag_waddr] <= i_req.tag_wdata;
        end
        r_rd_tag <= r_tag[i_req.tag_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.queue_we) begin
            r_queue[i_req.queue_waddr] <= i_req.queue_wdata;
        end
        r_rd_queue <= r_queue[i_req.queue_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.hit_we) begin
            r_hit[i_req.hit_waddr] <= i_req.hit_wdata;
        end
        r_rd_hit <= r_hit[i_req.hit_raddr];
    end
endmodule
`default_nettype wire

[design/mpmc_seq.sv]
// Sequencer of the match counter: clear, trie insert, link build, scan and count, count read.
// Drives the memories in mpmc_store through one request struct; uses mpmc_pkg.
`default_nettype none
module mpmc_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire mpmc_pkg::t_in_item  i_item,
    output logic                     busy,
    output logic                     o_done,
    output mpmc_pkg::t_out_item      o_result,
    output mpmc_pkg::t_mem_req       o_req,
    input  wire mpmc_pkg::t_mem_rd   i_rd
);
    import mpmc_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_CLR  = 19'h00002,
        S_PCW  = 19'h00004,
        S_ROW  = 19'h00008,
        S_BPOP = 19'h00010,
        S_BT   = 19'h00020,
        S_BCH  = 19'h00040,
        S_BCHW = 19'h00080,
        S_BFT  = 19'h00100,
        S_BG   = 19'h00200,
        S_BGW  = 19'h00400,
        S_BFP  = 19'h00800,
        S_TG   = 19'h01000,
        S_TGW  = 19'h02000,
        S_TFP  = 19'h04000,
        S_CNT  = 19'h08000,
        S_CW   = 19'h10000,
        S_CINC = 19'h20000,
        S_RDW  = 19'h40000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_quiet, n_quiet;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [NODE_W-1:0]    r_cursor, n_cursor;
    logic [NODE_W-1:0]    r_scan, n_scan;
    logic [NODE_W-1:0]    r_p, n_p;
    logic [NODE_W-1:0]    r_t, n_t;
    logic [NODE_W-1:0]    r_c, n_c;
    logic [LETTER_W-1:0]  r_k, n_k;
    logic [SWEEP_W-1:0]   r_j, n_j;
    logic [PAT_AW-1:0]    r_hid, n_hid;
    logic [QUEUE_W-1:0]   r_head, n_head;
    logic [QUEUE_W-1:0]   r_tail, n_tail;
    logic                 r_done, n_done;
    t_out_item            r_res, n_res;
    t_mem_req             req;
    logic [TAG_W-1:0]     tag_m1;
    logic                 last_letter;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;
    assign o_req    = req;
    assign tag_m1   = i_rd.tag - TAG_W'(1);
    assign last_letter = (r_k == LETTER_W'(ALPHA - 1));

    always_comb begin
        n_state  = r_state;
        n_quiet  = r_quiet;
        n_total  = r_total;
        n_cursor = r_cursor;
        n_scan   = r_scan;
        n_p      = r_p;
        n_t      = r_t;
        n_c      = r_c;
        n_k      = r_k;
        n_j      = r_j;
        n_hid    = r_hid;
        n_head   = r_head;
        n_tail   = r_tail;
        n_done   = 1'b0;
        n_res    = '0;
        req      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.action)
                        ACT_CLEAR: begin
                            n_total  = TOTAL_W'(1);
                            n_cursor = '0;
                            n_scan   = '0;
                            n_j      = '0;
                            n_quiet  = 1'b0;
                            n_state  = S_CLR;
                        end
                        ACT_PCHAR: begin
                            if (!is_letter(i_item.symbol)) begin
                                n_res.status = ST_BAD;
                                n_done       = 1'b1;
                            end else begin
                                n_k             = letter_of(i_item.symbol);
                                req.child_raddr = child_addr(r_cursor,
                                                             letter_of(i_item.symbol));
                                n_state         = S_PCW;
                            end
                        end
                        ACT_PEND: begin
                            if ({1'b0, i_item.pattern_id} < TAG_W'(PAT_LIMIT)) begin
                                req.tag_we    = 1'b1;
                                req.tag_waddr = r_cursor;
                                req.tag_wdata = {1'b0, i_item.pattern_id} + TAG_W'(1);
                            end
                            n_cursor = '0;
                            n_done   = 1'b1;
                        end
                        ACT_BUILD: begin
                            req.queue_we    = 1'b1;
                            req.queue_waddr = '0;
                            req.queue_wdata = '0;
                            n_head          = '0;
                            n_tail          = QUEUE_W'(1);
                            n_state         = S_BPOP;
                        end
                        ACT_TEXT: begin
                            if (!is_letter(i_item.symbol)) begin
                                n_scan = '0;
                                n_done = 1'b1;
                            end else begin
                                n_k     = letter_of(i_item.symbol);
                                n_p     = r_scan;
                                n_state = S_TG;
                            end
                        end
                        ACT_READ: begin
                            if ({1'b0, i_item.pattern_id} < TAG_W'(PAT_LIMIT)) begin
                                req.hit_raddr = PAT_AW'(i_item.pattern_id);
                                n_state       = S_RDW;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR: begin
                if (r_j < SWEEP_W'(ALPHA)) begin
                    req.child_we    = 1'b1;
                    req.child_waddr = CHILD_AW'(r_j);
                    req.child_wdata = '0;
                end
                req.hit_we    = 1'b1;
                req.hit_waddr = PAT_AW'(r_j);
                req.hit_wdata = '0;
                n_j           = r_j + SWEEP_W'(1);
                if (r_j == SWEEP_W'(PAT_LIMIT - 1)) begin
                    n_done  = !r_quiet;
                    n_quiet = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_PCW: begin
                if (i_rd.child != '0) begin
                    n_cursor = i_rd.child;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_total == TOTAL_W'(NODE_LIMIT)) begin
                    n_res.status = ST_FULL;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    req.child_we    = 1'b1;
                    req.child_waddr = child_addr(r_cursor, r_k);
                    req.child_wdata = r_total[NODE_W-1:0];
                    req.fail_we     = 1'b1;
                    req.fail_waddr  = r_total[NODE_W-1:0];
                    req.tag_we      = 1'b1;
                    req.tag_waddr   = r_total[NODE_W-1:0];
                    n_c             = r_total[NODE_W-1:0];
                    n_cursor        = r_total[NODE_W-1:0];
                    n_total         = r_total + TOTAL_W'(1);
                    n_j             = '0;
                    n_state         = S_ROW;
                end
            end
            S_ROW: begin
                req.child_we    = 1'b1;
                req.child_waddr = child_addr(r_c, r_j[LETTER_W-1:0]);
                req.child_wdata = '0;
                n_j             = r_j + SWEEP_W'(1);
                if (r_j[LETTER_W-1:0] == LETTER_W'(ALPHA - 1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BPOP: begin
                if (r_head < r_tail) begin
                    req.queue_raddr = r_head[NODE_W-1:0];
                    n_head          = r_head + QUEUE_W'(1);
                    n_state         = S_BT;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BT: begin
                n_t     = i_rd.queue;
                n_k     = '0;
                n_state = S_BCH;
            end
            S_BCH: begin
                req.child_raddr = child_addr(r_t, r_k);
                n_state         = S_BCHW;
            end
            S_BCHW: begin
                n_c = i_rd.child;
                if (i_rd.child == '0) begin
                    n_k     = r_k + LETTER_W'(1);
                    n_state = last_letter ? S_BPOP : S_BCH;
                end else if (r_t == '0) begin
                    req.fail_we    = 1'b1;
                    req.fail_waddr = i_rd.child;
                    req.fail_wdata = '0;
                    if (r_tail < QUEUE_W'(NODE_LIMIT)) begin
                        req.queue_we    = 1'b1;
                        req.queue_waddr = r_tail[NODE_W-1:0];
                        req.queue_wdata = i_rd.child;
                        n_tail          = r_tail + QUEUE_W'(1);
                    end
                    n_k     = r_k + LETTER_W'(1);
                    n_state = last_letter ? S_BPOP : S_BCH;
                end else begin
                    req.fail_raddr = r_t;
                    n_state        = S_BFT;
                end
            end
            S_BFT, S_BFP: begin
                n_p     = i_rd.fail;
                n_state = S_BG;
            end
            S_BG: begin
                req.child_raddr = child_addr(r_p, r_k);
                n_state         = S_BGW;
            end
            S_BGW: begin
                if (i_rd.child != '0 || r_p == '0) begin
                    req.fail_we    = 1'b1;
                    req.fail_waddr = r_c;
                    req.fail_wdata = i_rd.child;
                    if (r_tail < QUEUE_W'(NODE_LIMIT)) begin
                        req.queue_we    = 1'b1;
                        req.queue_waddr = r_tail[NODE_W-1:0];
                        req.queue_wdata = r_c;
                        n_tail          = r_tail + QUEUE_W'(1);
                    end
                    n_k     = r_k + LETTER_W'(1);
                    n_state = last_letter ? S_BPOP : S_BCH;
                end else begin
                    req.fail_raddr = r_p;
                    n_state        = S_BFP;
                end
            end
            S_TG: begin
                req.child_raddr = child_addr(r_p, r_k);
                n_state         = S_TGW;
            end
            S_TGW: begin
                if (i_rd.child != '0 || r_p == '0) begin
                    n_p     = i_rd.child;
                    n_scan  = i_rd.child;
                    n_state = S_CNT;
                end else begin
                    req.fail_raddr = r_p;
                    n_state        = S_TFP;
                end
            end
            S_TFP: begin
                n_p     = i_rd.fail;
                n_state = S_TG;
            end
            S_CNT: begin
                if (r_p == '0) begin
                    n_res.current_node = r_scan;
                    n_done             = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    req.tag_raddr  = r_p;
                    req.fail_raddr = r_p;
                    n_state        = S_CW;
                end
            end
            S_CW: begin
                n_p = i_rd.fail;
                if (i_rd.tag != '0 && tag_m1 < TAG_W'(PAT_LIMIT)) begin
                    req.hit_raddr = tag_m1[PAT_AW-1:0];
                    n_hid         = tag_m1[PAT_AW-1:0];
                    n_state       = S_CINC;
                end else begin
                    n_state = S_CNT;
                end
            end
            S_CINC: begin
                req.hit_we    = 1'b1;
                req.hit_waddr = r_hid;
                req.hit_wdata = (i_rd.hit == COUNT_MAX) ? i_rd.hit
                                                         : i_rd.hit + COUNT_W'(1);
                n_state       = S_CNT;
            end
            S_RDW: begin
                n_res.match_count = i_rd.hit;
                n_done            = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_quiet  <= 1'b1;
            r_total  <= TOTAL_W'(1);
            r_cursor <= '0;
            r_scan   <= '0;
            r_j      <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_quiet  <= n_quiet;
            r_total  <= n_total;
            r_cursor <= n_cursor;
            r_scan   <= n_scan;
            r_j      <= n_j;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_t   <= n_t;
        r_c   <= n_c;
        r_k   <= n_k;
        r_hid <= n_hid;
        r_res <= n_res;
    end
endmodule
`default_nettype wire

[design/multi_pattern_match_counter.sv]
// Top level of the multi-pattern match counter (Aho-Corasick over A-Z).
// Instantiates mpmc_seq and mpmc_store; uses mpmc_pkg.
//
//   channel   ports                      handshake
//   item in   i_item                     start high while busy low
//   result    o_result                   o_done high for one cycle
//
// Pattern char: follows the existing child, or creates a node and clears its child row (row sweep).
// Text char: follows failure links until a child exists, then walks the failure chain, counting each tagged node.
// Build: breadth-first over the node queue; reads every letter slot of a node and sets each child's failure link.
// Clear: sweep over the count memory and the root's child row; reset runs the same pass without o_done; busy meanwhile.
// Results cannot be stalled; the next item may start while o_done is high.
`default_nettype none
module multi_pattern_match_counter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire mpmc_pkg::t_in_item i_item,
    output logic                    busy,
    output logic                    o_done,
    output mpmc_pkg::t_out_item     o_result
);
    import mpmc_pkg::*;

    t_mem_req mem_req;
    t_mem_rd  mem_rd;

    mpmc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_req    (mem_req),
        .i_rd     (mem_rd)
    );

    mpmc_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd  (mem_rd)
    );
endmodule
`default_nettype wire
